// ===== sv/gdoc_pkg.sv =====
// ----------------------------------------------------------------------------
// gdoc_pkg
// Shared types, constants and table functions of the Gregorian date unit.
// ----------------------------------------------------------------------------
`default_nettype none

package gdoc_pkg;

  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned ORD_W   = 9;
  localparam int unsigned WD_W    = 3;
  localparam int unsigned LEN_W   = 5;
  localparam int unsigned OPND_W  = 15;
  localparam int unsigned QUOT_W  = 13;

  localparam logic [OPND_W-1:0] YEAR_SHIFT = 15'd400;
  localparam logic [ORD_W-1:0]  YEAR_DAYS  = 9'd365;

  localparam logic [MONTH_W-1:0] MONTH_FIRST = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB   = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_LAST  = 4'd12;

  typedef enum logic {
    ACT_DATE_TO_ORD = 1'b0,
    ACT_ORD_TO_DATE = 1'b1
  } action_t;

  typedef enum logic {
    RECIP_100 = 1'b0,
    RECIP_7   = 1'b1
  } recip_sel_t;

  typedef struct packed {
    logic [OPND_W-1:0] operand;
    recip_sel_t        sel;
  } mul_req_t;

  typedef struct packed {
    action_t            action;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [ORD_W-1:0]   ordinal;
  } req_t;

  typedef struct packed {
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [ORD_W-1:0]   ordinal;
    logic [WD_W-1:0]    weekday;
    logic [LEN_W-1:0]   month_length;
    logic               leap;
    logic               valid_res;
  } result_t;

  // days in month m, zero outside 1..12
  function automatic logic [LEN_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [LEN_W-1:0] l;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: l = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   l = 5'd30;
      4'd2:                                      l = leap ? 5'd29 : 5'd28;
      default:                                   l = 5'd0;
    endcase
    return l;
  endfunction

  // floor(31 * mm / 12) for the shifted month mm in 1..12
  function automatic logic [LEN_W-1:0] month_offset(input logic [MONTH_W-1:0] mm);
    logic [LEN_W-1:0] o;
    case (mm)
      4'd1:    o = 5'd2;
      4'd2:    o = 5'd5;
      4'd3:    o = 5'd7;
      4'd4:    o = 5'd10;
      4'd5:    o = 5'd12;
      4'd6:    o = 5'd15;
      4'd7:    o = 5'd18;
      4'd8:    o = 5'd20;
      4'd9:    o = 5'd23;
      4'd10:   o = 5'd25;
      4'd11:   o = 5'd28;
      4'd12:   o = 5'd31;
      default: o = 5'd0;
    endcase
    return o;
  endfunction

endpackage

`default_nettype wire

// ===== sv/gdoc_recip_mul.sv =====
// ----------------------------------------------------------------------------
// gdoc_recip_mul
// Shared divider by a constant: multiply by a scaled reciprocal of 100 or 7,
// product registered, quotient taken from the high bits.
// ----------------------------------------------------------------------------
`default_nettype none

module gdoc_recip_mul import gdoc_pkg::*; (
  input  wire logic              clk,
  input  wire mul_req_t          req,
  output logic [QUOT_W-1:0]      quot
);

  localparam logic [15:0] RECIP_K100 = 16'd20972;  // ceil(2^21 / 100)
  localparam logic [15:0] RECIP_K7   = 16'd37450;  // ceil(2^18 / 7)

  logic [30:0] prod;
  recip_sel_t  sel_q;
  logic [15:0] k;

  assign k = (req.sel == RECIP_7) ? RECIP_K7 : RECIP_K100;

  always_ff @(posedge clk) begin
    prod  <= 31'(req.operand) * 31'(k);
    sel_q <= req.sel;
  end

  assign quot = (sel_q == RECIP_7) ? prod[30:18] : {3'b000, prod[30:21]};

endmodule

`default_nettype wire

// ===== sv/gdoc_seq.sv =====
// ----------------------------------------------------------------------------
// gdoc_seq
// Sequencer: leap test, month walk one month per cycle, weekday congruence,
// divisions by 100 and by 7 through the shared reciprocal multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module gdoc_seq import gdoc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire req_t              in_req,
  output logic                   res_valid,
  input  wire logic              res_ready,
  output result_t                res,
  output mul_req_t               mul_req,
  input  wire logic [QUOT_W-1:0] quot
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_Q1, ST_LEAP, ST_WALK, ST_Q2, ST_SUM, ST_MOD, ST_WD, ST_DONE
  } state_t;

  state_t             state;
  action_t            act;
  logic [OPND_W-1:0]  yplus;
  logic [MONTH_W-1:0] mon;
  logic [DAY_W-1:0]   day;
  logic [ORD_W-1:0]   ord;
  logic               leap;
  logic [MONTH_W-1:0] m;
  logic [ORD_W-1:0]   acc;
  logic [ORD_W-1:0]   rest;
  logic [MONTH_W-1:0] r_mon;
  logic [DAY_W-1:0]   r_day;
  logic [ORD_W-1:0]   r_ord;
  logic [LEN_W-1:0]   r_len;
  logic [WD_W-1:0]    r_wd;
  logic               r_valid;
  logic [OPND_W-1:0]  yy;
  logic [OPND_W-1:0]  sum;

  logic [LEN_W-1:0]   l;
  logic [OPND_W-1:0]  q15;
  logic [OPND_W-1:0]  rem;
  logic               leap_next;
  logic [MONTH_W-1:0] mm;
  logic [OPND_W-1:0]  sum_next;
  logic [OPND_W-1:0]  wd_full;
  logic               mon_bad;
  logic               ord_bad;

  assign l         = month_len(m, leap);
  assign q15       = OPND_W'(quot);
  assign rem       = yplus - OPND_W'(q15 * 15'd100);
  assign leap_next = ((yplus[1:0] == 2'b00) && (rem != '0)) ||
                     ((rem == '0) && (quot[1:0] == 2'b00));
  assign mm        = (r_mon <= MONTH_FEB) ? r_mon + 4'd10 : r_mon - 4'd2;
  assign sum_next  = OPND_W'(r_day) + yy + (yy >> 2) + (q15 >> 2)
                   + OPND_W'(month_offset(mm)) - q15;
  assign wd_full   = sum - OPND_W'(q15 * 15'd7);
  assign mon_bad   = (mon < MONTH_FIRST) || (mon > MONTH_LAST);
  assign ord_bad   = (ord == '0) || (ord > YEAR_DAYS + ORD_W'(leap));

  assign in_ready  = (state == ST_IDLE);
  assign res_valid = (state == ST_DONE);
  assign res       = '{month: r_mon, day: r_day, ordinal: r_ord, weekday: r_wd,
                       month_length: r_len, leap: leap, valid_res: r_valid};

  always_comb begin
    mul_req.sel = (state == ST_MOD) ? RECIP_7 : RECIP_100;
    unique case (state)
      ST_Q1:   mul_req.operand = yplus;
      ST_Q2:   mul_req.operand = yy;
      default: mul_req.operand = sum;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            act     <= in_req.action;
            yplus   <= OPND_W'(in_req.year) + YEAR_SHIFT;
            mon     <= in_req.month;
            day     <= in_req.day;
            ord     <= in_req.ordinal;
            r_mon   <= '0;
            r_day   <= '0;
            r_ord   <= '0;
            r_len   <= '0;
            r_wd    <= '0;
            r_valid <= 1'b0;
            state   <= ST_Q1;
          end
        end
        ST_Q1: begin
          state <= ST_LEAP;
        end
        ST_LEAP: begin
          leap  <= leap_next;
          m     <= MONTH_FIRST;
          acc   <= '0;
          rest  <= ord;
          state <= ST_WALK;
        end
        ST_WALK: begin
          if (act == ACT_DATE_TO_ORD) begin
            if (mon_bad) begin
              state <= ST_DONE;
            end else if (m == mon) begin
              r_len <= l;
              if ((day != '0) && (day <= l)) begin
                r_mon   <= mon;
                r_day   <= day;
                r_ord   <= acc + ORD_W'(day);
                r_valid <= 1'b1;
                yy      <= yplus - OPND_W'(m <= MONTH_FEB);
                state   <= ST_Q2;
              end else begin
                state <= ST_DONE;
              end
            end else begin
              acc <= acc + ORD_W'(l);
              m   <= m + 4'd1;
            end
          end else begin
            if (ord_bad) begin
              state <= ST_DONE;
            end else if (rest <= ORD_W'(l)) begin
              r_mon   <= m;
              r_day   <= DAY_W'(rest);
              r_len   <= l;
              r_ord   <= ord;
              r_valid <= 1'b1;
              yy      <= yplus - OPND_W'(m <= MONTH_FEB);
              state   <= ST_Q2;
            end else begin
              rest <= rest - ORD_W'(l);
              m    <= m + 4'd1;
            end
          end
        end
        ST_Q2: begin
          state <= ST_SUM;
        end
        ST_SUM: begin
          sum   <= sum_next;
          state <= ST_MOD;
        end
        ST_MOD: begin
          state <= ST_WD;
        end
        ST_WD: begin
          r_wd  <= wd_full[WD_W-1:0];
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (res_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/gregorian_date_ordinal_converter_core.sv =====
// ----------------------------------------------------------------------------
// gregorian_date_ordinal_converter_core
// Gregorian day of year, month and day, weekday, month length and leap flag.
// ----------------------------------------------------------------------------
// One word in, one word out. The month walk steps one month a cycle and both
// divisions by 100 and the final modulo 7 share one registered reciprocal
// multiplier. s_tready is high only while the sequencer is idle; a finished
// result waits in the output register and the next word is taken meanwhile.
`default_nettype none

module gregorian_date_ordinal_converter_core import gdoc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // year_in, month_in, day_in, ordinal_in
  input  wire logic [0:0]  s_tuser,   // action
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // month_out, day_out, ordinal_out, weekday,
                                      // month_length, leap, zero pad
  output logic [0:0]       m_tuser    // valid_res
);

  req_t              req;
  result_t           res;
  logic              res_valid;
  logic              res_ready;
  mul_req_t          mul_req;
  logic [QUOT_W-1:0] quot;
  result_t           out_r;

  assign req = '{action: action_t'(s_tuser[0]), year: s_tdata[13:0],
                 month: s_tdata[17:14], day: s_tdata[22:18], ordinal: s_tdata[31:23]};

  gdoc_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_req    (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mul_req   (mul_req),
    .quot      (quot)
  );

  gdoc_recip_mul u_mul (
    .clk  (clk),
    .req  (mul_req),
    .quot (quot)
  );

  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
      out_r    <= res;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = {5'b00000, out_r.leap, out_r.month_length, out_r.weekday,
                    out_r.ordinal, out_r.day, out_r.month};
  assign m_tuser = out_r.valid_res;

  a_month_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> (m_tdata[3:0] != 4'd0) && (m_tdata[3:0] <= 4'd12))
    else $error("valid result with month out of range");

  a_weekday_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> (m_tdata[20:18] <= 3'd6))
    else $error("weekday out of range");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> (m_tdata[20:0] == 21'd0))
    else $error("invalid result carries date fields");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("ready while a word is in work");

endmodule

`default_nettype wire

// ===== dv/gregorian_date_ordinal_converter_core_test.sv =====
// ----------------------------------------------------------------------------
// gregorian_date_ordinal_converter_core_test
// Self-checking bench for the Gregorian date unit. Words of both actions go
// in with random gaps while the output side stalls at random; every result
// word is checked field by field against a calendar predictor in the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gregorian_date_ordinal_converter_core_test;
  import gdoc_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // year_in, month_in, day_in, ordinal_in
  logic [0:0]  s_tuser = '0;   // action
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // month_out, day_out, ordinal_out, weekday,
                               // month_length, leap, zero pad
  logic [0:0]  m_tuser;        // valid_res

  result_t pending_dates[$];
  result_t want;
  result_t got;
  int      errors = 0;
  int      words_checked = 0;
  int      date_words = 0;
  int      ordinal_words = 0;
  int      invalid_words = 0;
  bit      idle_off = 1'b0;
  int      stall_left = 0;

  gregorian_date_ordinal_converter_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #(64'd10_000_000);
    $display("*** FAILED ***");
    $finish;
  end

  function automatic bit is_leap(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned days_in_month(input int unsigned m, input bit lp);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return lp ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  function automatic result_t predict_calendar(input action_t act,
                                               input int unsigned y,
                                               input int unsigned mo,
                                               input int unsigned dy,
                                               input int unsigned od);
    result_t     r;
    bit          lp;
    int unsigned len, acc, rest, a, yy, mm, dow;
    r  = '0;
    lp = is_leap(y);
    r.leap = lp;
    if (act == ACT_DATE_TO_ORD) begin
      len = days_in_month(mo, lp);
      r.month_length = LEN_W'(len);
      if (len != 0 && dy >= 1 && dy <= len) begin
        acc = 0;
        for (int m = 1; m < mo; m++) acc += days_in_month(m, lp);
        r.month     = MONTH_W'(mo);
        r.day       = DAY_W'(dy);
        r.ordinal   = ORD_W'(acc + dy);
        r.valid_res = 1'b1;
      end
    end else if (od >= 1 && od <= 365 + lp) begin
      rest = od;
      for (int m = 1; m <= 12; m++) begin
        len = days_in_month(m, lp);
        if (rest <= len) begin
          r.month        = MONTH_W'(m);
          r.day          = DAY_W'(rest);
          r.month_length = LEN_W'(len);
          r.ordinal      = ORD_W'(od);
          r.valid_res    = 1'b1;
          break;
        end
        rest -= len;
      end
    end
    if (r.valid_res) begin
      a   = (14 - r.month) / 12;
      yy  = y + 400 - a;
      mm  = r.month + 12 * a - 2;
      dow = (r.day + yy + yy / 4 - yy / 100 + yy / 400 + (31 * mm) / 12) % 7;
      r.weekday = WD_W'(dow);
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_word(input action_t act, input int unsigned y,
                           input int unsigned mo, input int unsigned dy,
                           input int unsigned od);
    int gap;
    gap = idle_off ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {od[ORD_W-1:0], dy[DAY_W-1:0], mo[MONTH_W-1:0], y[YEAR_W-1:0]};
    do @(posedge clk); while (!s_tready);
    want = predict_calendar(act, y[YEAR_W-1:0], mo[MONTH_W-1:0], dy[DAY_W-1:0],
                            od[ORD_W-1:0]);
    pending_dates.push_back(want);
    if (act == ACT_DATE_TO_ORD) date_words++;
    else ordinal_words++;
    if (!want.valid_res) invalid_words++;
  endtask

  // hold the source until every pending word has come back
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_dates.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (idle_off) begin
      m_tready <= 1'b1;
    end else if (stall_left != 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < 25) begin
      m_tready   <= 1'b0;
      stall_left <= pick_gap();
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got.month        = m_tdata[3:0];
      got.day          = m_tdata[8:4];
      got.ordinal      = m_tdata[17:9];
      got.weekday      = m_tdata[20:18];
      got.month_length = m_tdata[25:21];
      got.leap         = m_tdata[26];
      got.valid_res    = m_tuser[0];
      if (pending_dates.size() == 0) begin
        $error("result word with nothing pending");
        errors++;
      end else begin
        want = pending_dates.pop_front();
        check_field("month_out", want.month, got.month);
        check_field("day_out", want.day, got.day);
        check_field("ordinal_out", want.ordinal, got.ordinal);
        check_field("weekday", want.weekday, got.weekday);
        check_field("month_length", want.month_length, got.month_length);
        check_field("leap", want.leap, got.leap);
        check_field("valid_res", want.valid_res, got.valid_res);
        check_field("pad", 0, m_tdata[31:27]);
        words_checked++;
      end
    end
  end

  task automatic test_directed();
    send_word(ACT_DATE_TO_ORD, 1, 1, 1, 0);
    send_word(ACT_DATE_TO_ORD, 2000, 12, 31, 511);
    send_word(ACT_DATE_TO_ORD, 2000, 2, 29, 0);
    send_word(ACT_DATE_TO_ORD, 1900, 2, 29, 0);
    send_word(ACT_DATE_TO_ORD, 2024, 2, 29, 0);
    send_word(ACT_DATE_TO_ORD, 2023, 0, 15, 0);
    send_word(ACT_DATE_TO_ORD, 2023, 13, 15, 0);
    send_word(ACT_DATE_TO_ORD, 2023, 15, 31, 511);
    send_word(ACT_DATE_TO_ORD, 2023, 6, 0, 0);
    send_word(ACT_DATE_TO_ORD, 2023, 4, 31, 0);
    send_word(ACT_DATE_TO_ORD, 0, 3, 1, 0);
    send_word(ACT_DATE_TO_ORD, 16383, 12, 31, 0);
    send_word(ACT_DATE_TO_ORD, 9999, 12, 31, 0);
    send_word(ACT_ORD_TO_DATE, 2023, 0, 0, 0);
    send_word(ACT_ORD_TO_DATE, 1, 15, 31, 1);
    send_word(ACT_ORD_TO_DATE, 2023, 0, 0, 365);
    send_word(ACT_ORD_TO_DATE, 2023, 0, 0, 366);
    send_word(ACT_ORD_TO_DATE, 2024, 0, 0, 366);
    send_word(ACT_ORD_TO_DATE, 2024, 0, 0, 511);
    send_word(ACT_ORD_TO_DATE, 2023, 0, 0, 31);
    send_word(ACT_ORD_TO_DATE, 2024, 0, 0, 59);
    send_word(ACT_ORD_TO_DATE, 2024, 0, 0, 60);
    send_word(ACT_ORD_TO_DATE, 2023, 0, 0, 60);
    send_word(ACT_ORD_TO_DATE, 0, 0, 0, 366);
    send_word(ACT_ORD_TO_DATE, 16383, 7, 9, 334);
  endtask

  // last day of each month and the day after as dates, the last day also as day of year; leap and common
  task automatic test_month_boundaries();
    int unsigned y, len, acc;
    for (int k = 0; k < 2; k++) begin
      y   = (k == 0) ? 2100 : 1600;
      acc = 0;
      for (int m = 1; m <= 12; m++) begin
        len = days_in_month(m, is_leap(y));
        acc += len;
        send_word(ACT_DATE_TO_ORD, y, m, len, 0);
        send_word(ACT_DATE_TO_ORD, y, m, len + 1, 0);
        send_word(ACT_ORD_TO_DATE, y, 0, 0, acc);
      end
    end
  endtask

  task automatic test_back_to_back();
    idle_off = 1'b1;
    for (int i = 0; i < 30; i++)
      send_word(action_t'($urandom_range(0, 1)), $urandom_range(1, 9999),
                $urandom_range(1, 12), $urandom_range(1, 28), $urandom_range(1, 365));
    drain_results();
    idle_off = 1'b0;
  endtask

  task automatic test_random(input int count);
    int          kind;
    int unsigned y, m;
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 50) idle_off = ~idle_off;
      if (i % 200 == 199) drain_results();
      kind = $urandom_range(0, 99);
      y = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 16383) : $urandom_range(1, 9999);
      if (kind < 40) begin
        m = $urandom_range(1, 12);
        send_word(ACT_DATE_TO_ORD, y, m, $urandom_range(1, days_in_month(m, is_leap(y))),
                  $urandom_range(0, 511));
      end else if (kind < 75) begin
        send_word(ACT_ORD_TO_DATE, y, $urandom_range(0, 15), $urandom_range(0, 31),
                  $urandom_range(1, 365 + is_leap(y)));
      end else begin
        send_word(action_t'($urandom_range(0, 1)), $urandom_range(0, 16383),
                  $urandom_range(0, 15), $urandom_range(0, 31), $urandom_range(0, 511));
      end
    end
    idle_off = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_month_boundaries();
    test_back_to_back();
    test_random(725);
    drain_results();
    repeat (40) @(posedge clk);
    $display("Checked %0d words: %0d date to day of year, %0d day of year to date,",
             words_checked, date_words, ordinal_words);
    $display("%0d of them out of range, with random gaps and output stalls.",
             invalid_words);
    if (errors == 0 && pending_dates.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/gdoc_pkg.sv
sv/gdoc_recip_mul.sv
sv/gdoc_seq.sv
sv/gregorian_date_ordinal_converter_core.sv
dv/gregorian_date_ordinal_converter_core_test.sv
